### hdl/assert_macros.svh
// Assertion macros used by the port checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication every clock, off during reset.
`define CHK_IMPL(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("%m: check failed");
// Check a condition every clock, including reset.
`define CHK_ALWAYS(label, clk, cond) \
  label: assert property (@(posedge clk) (cond)) else $error("%m: check failed");
`endif

### hdl/bni_pkg.sv
// Shared types and constants of the batch-normalization unit.
package bni_pkg;
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_NORM = 1'b1;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;
  typedef struct packed {
    logic        opcode;
    logic [11:0] channel;
    logic        in_range;
    logic signed [15:0] sample;
    logic signed [15:0] gamma;
    logic signed [15:0] beta;
    logic signed [15:0] mean;
    logic [32:0] sum;
  } bni_item_t;
  typedef struct packed {
    logic signed [15:0] value;
    logic [1:0]  status;
  } bni_result_t;
endpackage

### hdl/bni_front.sv
// Front part: accepts items, forms variance plus epsilon, queues work.
module bni_front #(
  parameter int CHANNELS = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic opcode,
  input  logic [5:0] channel,
  input  logic signed [15:0] sample,
  input  logic signed [15:0] gamma,
  input  logic signed [15:0] beta,
  input  logic signed [15:0] mean,
  input  logic [31:0] variance,
  input  logic [31:0] epsilon,
  output logic q_valid,
  input  logic q_take,
  output bni_pkg::bni_item_t q_item
);
  localparam int DEPTH = 2;
  bni_pkg::bni_item_t slots [DEPTH];
  logic rd_ptr, wr_ptr;
  logic [1:0] count;
  logic wr_en, rd_en;
  bni_pkg::bni_item_t item_in;

  assign full = (count == 2'(DEPTH));
  assign q_valid = (count != 2'd0);
  assign q_item = slots[rd_ptr];
  assign wr_en = push && !full;
  assign rd_en = q_take && q_valid;

  always_comb begin
    item_in.opcode = opcode;
    item_in.channel = 12'(channel);
    item_in.in_range = (32'(channel) < 32'(CHANNELS));
    item_in.sample = sample;
    item_in.gamma = gamma;
    item_in.beta = beta;
    item_in.mean = mean;
    item_in.sum = {1'b0, variance} + {1'b0, epsilon};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr_en) wr_ptr <= ~wr_ptr;
      if (rd_en) rd_ptr <= ~rd_ptr;
      count <= count + 2'(wr_en) - 2'(rd_en);
    end
    if (wr_en) slots[wr_ptr] <= item_in;
  end
endmodule

### hdl/bni_back.sv
// Back part: square root and divide for loads, multiply-add for samples.
module bni_back #(
  parameter int CHANNELS = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_take,
  input  bni_pkg::bni_item_t q_item,
  output logic res_valid,
  output bni_pkg::bni_result_t res,
  input  logic res_take
);
  typedef enum logic [2:0] {S_IDLE, S_READ, S_MUL, S_SQRT, S_DIV, S_DONE} state_t;
  state_t state;
  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [31:0] factor_mem [CHANNELS];
  logic [15:0] mean_mem [CHANNELS];
  logic [15:0] bias_mem [CHANNELS];
  logic [31:0] f_rd;
  logic [15:0] m_rd, b_rd;

  bni_pkg::bni_item_t it;
  bni_pkg::bni_result_t wres;  // result being built, moved to res when done
  logic [AW-1:0] addr;
  logic [63:0] rx;       // remaining radicand
  logic [32:0] root;
  logic [5:0]  step;
  logic [47:0] dnum;     // radicand, then dividend, shifted out from the top
  logic [33:0] drem;
  logic [47:0] quo;
  logic signed [48:0] prod;
  logic signed [16:0] diff;

  logic [65:0] trial;
  logic [34:0] dtrial;
  logic [15:0] gmag;
  logic signed [49:0] rsum;
  logic signed [33:0] rq;
  logic load_sat, load_ok, done_fire;

  assign addr = it.channel[AW-1:0];
  assign q_take = (state == S_IDLE);
  assign trial = {rx, dnum[47:46]} - {31'd0, root, 2'b01};
  assign dtrial = {drem, dnum[47]} - {2'b00, root};
  assign gmag = it.gamma[15] ? 16'(-it.gamma) : 16'(it.gamma);
  assign rsum = (50'(prod) + 50'sd32768) >>> 16;
  assign rq = 34'(rsum) + 34'(signed'(b_rd));
  assign load_sat = it.gamma[15] ? (quo > 48'h8000_0000) : (quo > 48'h7fff_ffff);
  assign load_ok = it.in_range && (it.opcode == bni_pkg::OP_LOAD) &&
                   (wres.status != bni_pkg::ST_ZERO);
  assign done_fire = (state == S_DONE) && (!res_valid || res_take);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (done_fire) res_valid <= 1'b1;
      else if (res_take) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (q_valid) begin
          it <= q_item;
          state <= S_READ;
        end
        S_READ: begin
          wres.value <= '0;
          wres.status <= bni_pkg::ST_OK;
          if (!it.in_range) state <= S_DONE;
          else if (it.opcode == bni_pkg::OP_NORM) begin
            f_rd <= factor_mem[addr];
            m_rd <= mean_mem[addr];
            b_rd <= bias_mem[addr];
            state <= S_MUL;
            step <= 6'd0;
          end else if (it.sum == 33'd0) begin
            wres.status <= bni_pkg::ST_ZERO;
            state <= S_DONE;
          end else begin
            // radicand is sum << 30, consumed two bits per step
            rx <= 64'd0;
            root <= 33'd0;
            dnum <= {1'b0, it.sum, 14'd0};
            step <= 6'd0;
            state <= S_SQRT;
          end
        end
        S_MUL: begin
          if (step == 6'd0) begin
            diff <= 17'(it.sample) - 17'(signed'(m_rd));
            step <= 6'd1;
          end else if (step == 6'd1) begin
            prod <= 49'(diff) * 49'(signed'(f_rd));
            step <= 6'd2;
          end else begin
            if (rq > 34'sd32767) begin
              wres.value <= 16'sh7fff; wres.status <= bni_pkg::ST_SAT;
            end else if (rq < -34'sd32768) begin
              wres.value <= 16'sh8000; wres.status <= bni_pkg::ST_SAT;
            end else wres.value <= 16'(rq);
            state <= S_DONE;
          end
        end
        S_SQRT: begin
          // bring in the next radicand pair from the top of dnum
          if (!trial[65]) begin
            rx <= trial[63:0];
            root <= {root[31:0], 1'b1};
          end else begin
            rx <= {rx[61:0], dnum[47:46]};
            root <= {root[31:0], 1'b0};
          end
          if (step == 6'd31) begin
            state <= S_DIV;
            step <= 6'd0;
            drem <= 34'd0;
            dnum <= {1'b0, gmag, 31'd0};
            quo <= 48'd0;
          end else begin
            step <= step + 6'd1;
            dnum <= {dnum[45:0], 2'b00};
          end
        end
        S_DIV: begin
          if (!dtrial[34]) begin
            drem <= dtrial[33:0];
            quo <= {quo[46:0], 1'b1};
          end else begin
            drem <= {drem[32:0], dnum[47]};
            quo <= {quo[46:0], 1'b0};
          end
          dnum <= {dnum[46:0], 1'b0};
          step <= step + 6'd1;
          if (step == 6'd47) state <= S_DONE;
        end
        S_DONE: if (done_fire) begin
          if (load_ok) begin
            if (load_sat)
              factor_mem[addr] <= it.gamma[15] ? 32'h8000_0000 : 32'h7fff_ffff;
            else
              factor_mem[addr] <= it.gamma[15] ? 32'(-quo[31:0]) : quo[31:0];
            mean_mem[addr] <= it.mean;
            bias_mem[addr] <= it.beta;
          end
          res.value <= wres.value;
          res.status <= (load_ok && load_sat) ? bni_pkg::ST_SAT : wres.status;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### hdl/batch_norm_inference_unit.sv
// Top level of the batch-normalization inference unit.
// A load item passes through a 32-step square root and a 48-step divide; a
// sample item passes through the multiply-add; a two-entry queue lets the
// front accept while the back works.
module batch_norm_inference_unit #(
  parameter int CHANNELS = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic opcode,
  input  logic [5:0] channel,
  input  logic signed [15:0] sample,
  input  logic signed [15:0] gamma,
  input  logic signed [15:0] beta,
  input  logic signed [15:0] mean,
  input  logic [31:0] variance,
  output logic empty,
  input  logic pop,
  output logic signed [15:0] value,
  output logic [1:0] status,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [31:0] cfg_data
);
  logic [31:0] epsilon;
  logic q_valid, q_take, res_valid;
  bni_pkg::bni_item_t q_item;
  bni_pkg::bni_result_t res;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) epsilon <= 32'd1;
    else if (cfg_valid) epsilon <= cfg_data;
  end

  bni_front #(.CHANNELS(CHANNELS)) u_front (
    .clk, .rst, .push, .full, .opcode, .channel, .sample, .gamma, .beta,
    .mean, .variance, .epsilon, .q_valid, .q_take, .q_item);

  bni_back #(.CHANNELS(CHANNELS)) u_back (
    .clk, .rst, .q_valid, .q_take, .q_item, .res_valid, .res,
    .res_take(pop));

  assign empty = !res_valid;
  assign value = res.value;
  assign status = res.status;
endmodule

### hdl/bni_checker.sv
// Port checker for the batch-normalization unit, bound to the top level.
`include "assert_macros.svh"
module bni_checker (
  input logic clk,
  input logic rst,
  input logic empty,
  input logic pop,
  input logic [1:0] status,
  input logic signed [15:0] value
);
  `CHK_ALWAYS(a_rst_empty, clk, $past(rst) |-> empty)
  `CHK_IMPL(a_status_code, clk, rst, !empty |-> status != 2'd3)
  `CHK_IMPL(a_zero_val, clk, rst, (!empty && status == 2'd1) |-> value == 16'sd0)
endmodule
bind batch_norm_inference_unit bni_checker u_chk (.*);
